>>> rtl/ddo_pkg.sv
// Shared types, constants and the arctangent table for the differential-drive
// odometry block. No dependencies.
package ddo_pkg;

  // Field widths
  localparam int DELTA_W = 16;
  localparam int POS_W   = 32;
  localparam int ANG_W   = 32;
  localparam int CFG_W   = 32;

  // Configuration register indexes
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_METRES_PER_COUNT = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TURN_PER_COUNT   = 1'd1;
  localparam logic [CFG_W-1:0] METRES_PER_COUNT_RST = 32'd49513;
  localparam logic [CFG_W-1:0] TURN_PER_COUNT_RST   = 32'd15760;

  // Algorithm constants
  localparam int CORDIC_STEPS  = 16;
  localparam int POS_FRAC_BITS = 16;
  localparam int STEP_W        = $clog2(CORDIC_STEPS);
  localparam int ATAN_IDX_W    = 5;

  // Distance: sum (17b) times unsigned count scale (33b signed) in Q.33,
  // rounded to Q.(POS_FRAC_BITS+6)
  localparam int SUM_IN_W = DELTA_W + 1;
  localparam int RAW_W    = SUM_IN_W + CFG_W + 1;
  localparam int D_SHIFT  = 27 - POS_FRAC_BITS;
  localparam int D_W      = RAW_W - D_SHIFT;
  localparam logic signed [RAW_W-1:0] D_HALF = RAW_W'(64'd1 << (D_SHIFT - 1));

  // CORDIC datapath: Q.30 x/y and binary-angle residual, two guard bits
  localparam int XY_W = 34;
  localparam int Z_W  = ANG_W + 2;
  localparam logic signed [XY_W-1:0] GAIN_INV_Q30 = XY_W'(652032874);
  localparam logic signed [Z_W-1:0]  QUARTER_TURN = Z_W'(64'd1073741824);
  localparam logic signed [Z_W-1:0]  HALF_TURN    = Z_W'(64'd2147483648);

  // cos/sin rounded to Q.16
  localparam int CS_SHIFT = 14;
  localparam int C_W      = XY_W - CS_SHIFT;
  localparam logic signed [XY_W-1:0] CS_HALF = XY_W'(64'd1 << (CS_SHIFT - 1));

  // Projection product d*cos, rounded back to the position format
  localparam int P_W      = D_W + C_W;
  localparam int P_SHIFT  = 22;
  localparam int DX_W     = P_W - P_SHIFT;
  localparam int ACC_W    = DX_W + 1;
  localparam logic signed [P_W-1:0] P_HALF = P_W'(64'd1 << (P_SHIFT - 1));

  // Datapath command word from the controller
  typedef struct packed {
    logic              load;
    logic              mul;
    logic              fold;
    logic              rotate;
    logic [STEP_W-1:0] step_idx;
    logic              round;
    logic              proj;
    logic              commit;
  } ddo_cmd_t;

  function automatic logic [ANG_W-1:0] atan_lookup(input logic [ATAN_IDX_W-1:0] idx);
    logic [ANG_W-1:0] v;
    case (idx)
      5'd0:    v = 32'h20000000;
      5'd1:    v = 32'h12E4051E;
      5'd2:    v = 32'h09FB385B;
      5'd3:    v = 32'h051111D4;
      5'd4:    v = 32'h028B0D43;
      5'd5:    v = 32'h0145D7E1;
      5'd6:    v = 32'h00A2F61E;
      5'd7:    v = 32'h00517C55;
      5'd8:    v = 32'h0028BE53;
      5'd9:    v = 32'h00145F2F;
      5'd10:   v = 32'h000A2F98;
      5'd11:   v = 32'h000517CC;
      5'd12:   v = 32'h00028BE6;
      5'd13:   v = 32'h000145F3;
      5'd14:   v = 32'h0000A2FA;
      5'd15:   v = 32'h0000517D;
      5'd16:   v = 32'h000028BE;
      5'd17:   v = 32'h0000145F;
      5'd18:   v = 32'h00000A30;
      5'd19:   v = 32'h00000518;
      5'd20:   v = 32'h0000028C;
      5'd21:   v = 32'h00000146;
      5'd22:   v = 32'h000000A3;
      5'd23:   v = 32'h00000051;
      5'd24:   v = 32'h00000029;
      5'd25:   v = 32'h00000014;
      5'd26:   v = 32'h0000000A;
      5'd27:   v = 32'h00000005;
      5'd28:   v = 32'h00000003;
      5'd29:   v = 32'h00000001;
      default: v = 32'h00000000;
    endcase
    return v;
  endfunction

endpackage

>>> rtl/ddo_if.sv
// Valid/ready channel interfaces for encoder deltas in and pose out.
// Depends on ddo_pkg.
interface ddo_in_if;
  import ddo_pkg::*;
  logic                      valid;
  logic                      ready;
  logic signed [DELTA_W-1:0] left_delta;
  logic signed [DELTA_W-1:0] right_delta;
  modport source (output valid, left_delta, right_delta, input ready);
  modport sink (input valid, left_delta, right_delta, output ready);
endinterface

interface ddo_out_if;
  import ddo_pkg::*;
  logic                    valid;
  logic                    ready;
  logic signed [POS_W-1:0] pos_x;
  logic signed [POS_W-1:0] pos_y;
  logic [ANG_W-1:0]        heading;
  modport source (output valid, pos_x, pos_y, heading, input ready);
  modport sink (input valid, pos_x, pos_y, heading, output ready);
endinterface

>>> rtl/ddo_ctrl.sv
// Sequencing controller for the odometry datapath: handshakes, step counter
// and the command word. Depends on ddo_pkg.
module ddo_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  output ddo_pkg::ddo_cmd_t cmd
);
  import ddo_pkg::*;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_MUL    = 3'd1;
  localparam logic [2:0] S_FOLD   = 3'd2;
  localparam logic [2:0] S_ROT    = 3'd3;
  localparam logic [2:0] S_ROUND  = 3'd4;
  localparam logic [2:0] S_PROJ   = 3'd5;
  localparam logic [2:0] S_COMMIT = 3'd6;

  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(CORDIC_STEPS - 1);

  logic [2:0]        state, state_next;
  logic [STEP_W-1:0] step, step_next;
  logic              out_valid_next;
  logic              slot_free;

  assign in_ready  = (state == S_IDLE);
  assign slot_free = !out_valid || out_ready;

  always_comb begin
    state_next     = state;
    step_next      = step;
    cmd            = '0;
    cmd.step_idx   = step;
    out_valid_next = out_valid && !out_ready;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_MUL;
        end
      end
      S_MUL: begin
        cmd.mul    = 1'b1;
        state_next = S_FOLD;
      end
      S_FOLD: begin
        cmd.fold   = 1'b1;
        step_next  = '0;
        state_next = S_ROT;
      end
      S_ROT: begin
        cmd.rotate = 1'b1;
        if (step == LAST_STEP) begin
          state_next = S_ROUND;
        end else begin
          step_next = step + 1'b1;
        end
      end
      S_ROUND: begin
        cmd.round  = 1'b1;
        state_next = S_PROJ;
      end
      S_PROJ: begin
        cmd.proj   = 1'b1;
        state_next = S_COMMIT;
      end
      S_COMMIT: begin
        // hold until the previous pose beat has left the output
        if (slot_free) begin
          cmd.commit     = 1'b1;
          out_valid_next = 1'b1;
          state_next     = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      step      <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      step      <= step_next;
      out_valid <= out_valid_next;
    end
  end

endmodule

>>> rtl/ddo_datapath.sv
// Arithmetic datapath: distance and heading products, shared CORDIC stage,
// projection and saturating pose accumulators. Depends on ddo_pkg.
module ddo_datapath (
  input  logic                               clk,
  input  logic                               rst,
  input  ddo_pkg::ddo_cmd_t                  cmd,
  input  logic                               cfg_write,
  input  logic [ddo_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [ddo_pkg::CFG_W-1:0]          cfg_data,
  input  logic signed [ddo_pkg::DELTA_W-1:0] left_delta,
  input  logic signed [ddo_pkg::DELTA_W-1:0] right_delta,
  output logic signed [ddo_pkg::POS_W-1:0]   pos_x,
  output logic signed [ddo_pkg::POS_W-1:0]   pos_y,
  output logic [ddo_pkg::ANG_W-1:0]          heading
);
  import ddo_pkg::*;

  localparam logic signed [ACC_W-1:0] POS_MAX = ACC_W'({1'b0, {(POS_W-1){1'b1}}});
  localparam logic signed [ACC_W-1:0] POS_MIN = -POS_MAX - 1;

  logic [CFG_W-1:0] metres_per_count;
  logic [CFG_W-1:0] turn_per_count;

  logic signed [POS_W-1:0] x_acc, y_acc;
  logic [ANG_W-1:0]        heading_acc;

  logic signed [DELTA_W-1:0] left_r, right_r;
  logic signed [D_W-1:0]     distance;
  logic [ANG_W-1:0]          heading_new;
  logic signed [Z_W-1:0]     z;
  logic signed [XY_W-1:0]    cx, cy;
  logic                      neg;
  logic signed [C_W-1:0]     cos_q, sin_q;
  logic signed [P_W-1:0]     px, py;

  // Distance and heading products
  logic signed [SUM_IN_W-1:0] sum_s, diff_s;
  logic signed [RAW_W-1:0]    raw, raw_rnd, raw_sh;
  logic [ANG_W-1:0]           diff_ext, turn_prod;

  always_comb begin
    sum_s     = SUM_IN_W'(left_r) + SUM_IN_W'(right_r);
    diff_s    = SUM_IN_W'(right_r) - SUM_IN_W'(left_r);
    raw       = RAW_W'(sum_s) * RAW_W'($signed({1'b0, metres_per_count}));
    raw_rnd   = raw + D_HALF;
    raw_sh    = raw_rnd >>> D_SHIFT;
    diff_ext  = ANG_W'(diff_s);
    turn_prod = diff_ext * turn_per_count;
  end

  // Fold heading into the right half plane
  logic signed [Z_W-1:0] z_in, z_fold;
  logic                  fold_neg;

  always_comb begin
    z_in     = Z_W'($signed(heading_new));
    z_fold   = z_in;
    fold_neg = 1'b0;
    if (z_in > QUARTER_TURN) begin
      z_fold   = z_in - HALF_TURN;
      fold_neg = 1'b1;
    end else if (z_in < -QUARTER_TURN) begin
      z_fold   = z_in + HALF_TURN;
      fold_neg = 1'b1;
    end
  end

  // One CORDIC micro-rotation per cycle
  logic signed [XY_W-1:0] xs, ys;
  logic signed [Z_W-1:0]  atan_z;

  always_comb begin
    xs     = cx >>> cmd.step_idx;
    ys     = cy >>> cmd.step_idx;
    atan_z = $signed(Z_W'(atan_lookup(ATAN_IDX_W'(cmd.step_idx))));
  end

  // Rounding of cos/sin, and of the projections
  logic signed [XY_W-1:0] cx_rnd, cy_rnd;
  logic signed [C_W-1:0]  cos_r, sin_r;
  logic signed [P_W-1:0]  px_rnd, py_rnd;
  logic signed [ACC_W-1:0] x_sum, y_sum;

  always_comb begin
    cx_rnd = (cx + CS_HALF) >>> CS_SHIFT;
    cy_rnd = (cy + CS_HALF) >>> CS_SHIFT;
    cos_r  = cx_rnd[C_W-1:0];
    sin_r  = cy_rnd[C_W-1:0];
    px_rnd = (px + P_HALF) >>> P_SHIFT;
    py_rnd = (py + P_HALF) >>> P_SHIFT;
    x_sum  = ACC_W'(x_acc) + ACC_W'($signed(px_rnd[DX_W-1:0]));
    y_sum  = ACC_W'(y_acc) + ACC_W'($signed(py_rnd[DX_W-1:0]));
  end

  function automatic logic signed [POS_W-1:0] sat_pos(input logic signed [ACC_W-1:0] v);
    logic signed [POS_W-1:0] r;
    if (v > POS_MAX) begin
      r = POS_MAX[POS_W-1:0];
    end else if (v < POS_MIN) begin
      r = POS_MIN[POS_W-1:0];
    end else begin
      r = v[POS_W-1:0];
    end
    return r;
  endfunction

  // Configuration and pose state
  always_ff @(posedge clk) begin
    if (rst) begin
      metres_per_count <= METRES_PER_COUNT_RST;
      turn_per_count   <= TURN_PER_COUNT_RST;
      x_acc            <= '0;
      y_acc            <= '0;
      heading_acc      <= '0;
    end else begin
      if (cfg_write) begin
        unique case (cfg_index)
          REG_METRES_PER_COUNT: metres_per_count <= cfg_data;
          REG_TURN_PER_COUNT:   turn_per_count   <= cfg_data;
          default: ;
        endcase
      end
      if (cmd.commit) begin
        x_acc       <= sat_pos(x_sum);
        y_acc       <= sat_pos(y_sum);
        heading_acc <= heading_new;
      end
    end
  end

  // Working registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      left_r  <= left_delta;
      right_r <= right_delta;
    end
    if (cmd.mul) begin
      distance    <= raw_sh[D_W-1:0];
      heading_new <= heading_acc + turn_prod;
    end
    if (cmd.fold) begin
      z   <= z_fold;
      neg <= fold_neg;
      cx  <= GAIN_INV_Q30;
      cy  <= '0;
    end
    if (cmd.rotate) begin
      if (!z[Z_W-1]) begin
        cx <= cx - ys;
        cy <= cy + xs;
        z  <= z - atan_z;
      end else begin
        cx <= cx + ys;
        cy <= cy - xs;
        z  <= z + atan_z;
      end
    end
    if (cmd.round) begin
      cos_q <= neg ? -cos_r : cos_r;
      sin_q <= neg ? -sin_r : sin_r;
    end
    if (cmd.proj) begin
      px <= P_W'(distance) * P_W'(cos_q);
      py <= P_W'(distance) * P_W'(sin_q);
    end
  end

  assign pos_x   = x_acc;
  assign pos_y   = y_acc;
  assign heading = heading_acc;

endmodule

>>> rtl/differential_drive_odometry.sv
// Top level of the differential-drive odometry block: controller plus datapath.
// Depends on ddo_pkg, ddo_in_if, ddo_out_if, ddo_ctrl and ddo_datapath.
//
// Usage:
//   deltas  - input channel; one beat carries the signed left and right encoder
//             count changes of one sample period.
//   pose    - output channel; one beat per input beat with the updated x, y
//             (signed Q16.16 metres, saturating) and heading (binary angle,
//             2^32 per turn, wrapping).
//   cfg_*   - write port for metres_per_count (index 0) and turn_per_count
//             (index 1); write only while no beat is in flight.
// Timing: deltas.ready is high only while the controller idles. An accepted
//   beat passes through the distance and heading multiplies, the quadrant
//   fold, CORDIC_STEPS micro-rotations on the shared CORDIC rotator, rounding
//   of cos/sin and the projection multiplies, then commits. The commit
//   registers the pose and its valid flag; a new beat can be accepted the
//   cycle after the commit, so items do not overlap.
// Reset clears the pose to zero, restores the default register values and
//   drops any pending output beat.
// Stall: the pose register holds until taken. A following item runs through
//   the CORDIC meanwhile and then waits in commit until the output is free.
module differential_drive_odometry (
  input  logic                          clk,
  input  logic                          rst,
  ddo_in_if.sink                        deltas,
  ddo_out_if.source                     pose,
  input  logic                          cfg_write,
  input  logic [ddo_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [ddo_pkg::CFG_W-1:0]     cfg_data
);
  import ddo_pkg::*;

  ddo_cmd_t cmd;

  // Sequencing: handshakes and the per-state command word
  ddo_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (deltas.valid),
    .in_ready  (deltas.ready),
    .out_valid (pose.valid),
    .out_ready (pose.ready),
    .cmd       (cmd)
  );

  // Arithmetic; the pose accumulators double as the output register
  ddo_datapath u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .cfg_write   (cfg_write),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .left_delta  (deltas.left_delta),
    .right_delta (deltas.right_delta),
    .pos_x       (pose.pos_x),
    .pos_y       (pose.pos_y),
    .heading     (pose.heading)
  );

endmodule
